/* rtl/core/bmpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bmpd_pkg;

    // Parser phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_PALETTE = 3'd1;
    localparam logic [2:0] PH_PIXELS  = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;
    localparam logic [2:0] PH_ERROR   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_PIXEL     = 2'd0;
    localparam logic [1:0] ST_SIGNATURE = 2'd1;
    localparam logic [1:0] ST_DEPTH     = 2'd2;
    localparam logic [1:0] ST_DIMENSION = 2'd3;

    // Supported pixel depths
    localparam logic [1:0] DC_1  = 2'd0;
    localparam logic [1:0] DC_4  = 2'd1;
    localparam logic [1:0] DC_8  = 2'd2;
    localparam logic [1:0] DC_24 = 2'd3;

    // Header layout
    localparam logic [15:0] SIGNATURE   = 16'h4D42;
    localparam logic [5:0]  HDR_LAST    = 6'd53;
    localparam logic [5:0]  OFF_SIG_END = 6'd2;
    localparam logic [5:0]  OFF_WIDTH   = 6'd18;
    localparam logic [5:0]  OFF_HEIGHT  = 6'd22;
    localparam logic [5:0]  OFF_DEPTH   = 6'd28;
    localparam logic [5:0]  OFF_COLORS  = 6'd46;

    // Palette memory control
    typedef struct packed {
        logic clear;
        logic wr_en;
        logic rd_en;
        logic rd_inrange;
    } pal_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/bmpd_pal_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module bmpd_pal_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bmpd_pkg::pal_ctl_t ctl,
    input  logic [AW-1:0]      wr_addr,
    input  logic [23:0]        wr_data,
    input  logic [AW-1:0]      rd_addr,
    output logic [23:0]        rd_data,
    output logic               rd_hit
);

    logic [23:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [23:0]      rd_data_reg;
    logic             rd_hit_reg;

    // Entry storage, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Per-entry valid flags; an unwritten entry reads as black
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr] & ctl.rd_inrange;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_hit  = rd_hit_reg;

endmodule

`default_nettype wire

/* rtl/core/bmp_pixel_stream_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Streaming BMP decoder. Feed the file one byte per word on the byte channel;
// a word with kind set restarts the parser and empties the palette. The 54
// header bytes give no output unless the header check fails, in which case a
// single word carries the error status and the rest of the file is ignored.
// Pixel words leave one per cycle while pix_ready allows it, through a
// three-stage path (expander, palette memory read, output register). A byte
// yields up to 8 pixels at 1 bpp, 2 at 4 bpp and 1 at 8 bpp; the expander
// issues them one at a time, bounded by the single read port of the palette
// memory, and takes the next byte as it issues the last. Palette valid flags
// clear in the reset cycle itself, so no clearing pass is needed.
module bmp_pixel_stream_decoder #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        pix_valid,
    input  logic        pix_ready,
    output logic [11:0] pixel_x,
    output logic [11:0] pixel_y,
    output logic [7:0]  blue,
    output logic [7:0]  green,
    output logic [7:0]  red,
    output logic [1:0]  status,
    output logic        last_of_run,
    output logic        image_done
);

    import bmpd_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RBW = $clog2(3 * MAX_WIDTH + 4);
    localparam int PAW = $clog2(PALETTE_DEPTH);
    localparam int BW  = CW + 5;

    // Parser state
    logic [2:0]     phase_reg,   phase_next;
    logic [5:0]     hdr_idx_reg, hdr_idx_next;
    logic [15:0]    sig_reg,     sig_next;
    logic [31:0]    width_reg,   width_next;
    logic [31:0]    height_reg,  height_next;
    logic [15:0]    depth_reg,   depth_next;
    logic [31:0]    pcount_reg,  pcount_next;
    logic [33:0]    pal_idx_reg, pal_idx_next;
    logic [15:0]    asm_reg,     asm_next;
    logic [1:0]     dcode_reg,   dcode_next;
    logic [RBW-1:0] row_len_reg, row_len_next;
    logic [RBW-1:0] rbi_reg,     rbi_next;
    logic [1:0]     pos_reg,     pos_next;
    logic [CW-1:0]  col_reg,     col_next;
    logic [RW-1:0]  row_reg,     row_next;
    logic [15:0]    partial_reg, partial_next;

    // Expander stage
    logic [3:0]     exp_cnt_reg,    exp_cnt_next;
    logic [7:0]     exp_byte_reg,   exp_byte_next;
    logic [CW-1:0]  exp_col_reg,    exp_col_next;
    logic [RW-1:0]  exp_row_reg,    exp_row_next;
    logic           exp_direct_reg, exp_direct_next;
    logic [23:0]    exp_color_reg,  exp_color_next;
    logic [1:0]     exp_status_reg, exp_status_next;

    // Read stage
    logic           r_valid_reg;
    logic           r_direct_reg;
    logic [23:0]    r_color_reg;
    logic [1:0]     r_status_reg;
    logic [11:0]    r_x_reg;
    logic [11:0]    r_y_reg;
    logic           r_last_reg;
    logic           r_done_reg;

    // Output register
    logic           o_valid_reg;
    logic [11:0]    o_x_reg;
    logic [11:0]    o_y_reg;
    logic [23:0]    o_color_reg;
    logic [1:0]     o_status_reg;
    logic           o_last_reg;
    logic           o_done_reg;

    // Loads into the expander
    logic           load_e;
    logic [3:0]     ld_cnt;
    logic [7:0]     ld_byte;
    logic [CW-1:0]  ld_col;
    logic [RW-1:0]  ld_row;
    logic           ld_direct;
    logic [23:0]    ld_color;
    logic [1:0]     ld_status;

    logic           accept;
    logic           advance;
    logic           issue;

    // Header check
    logic [1:0]     hdr_status;
    logic [1:0]     dcode_chk;
    logic           depth_ok;
    logic           dim_bad;
    logic [CW-1:0]  wn;
    logic [BW-1:0]  row_bits;
    logic [BW:0]    rb_round;
    logic [RBW-1:0] row_len_calc;
    logic [31:0]    pal_default;
    logic [31:0]    hm1;
    logic [5:0]     off_w;
    logic [5:0]     off_h;
    logic [5:0]     off_d;
    logic [5:0]     off_c;

    // Palette and pixel helpers
    logic [33:0]    pal_inc;
    logic           pal_end;
    logic           pal_inrange;
    logic [CW-1:0]  remaining;
    logic [CW+3:0]  rem_x;
    logic [3:0]     per_byte;
    logic [3:0]     n_pal;
    logic [RBW-1:0] rbi_inc;
    logic           row_end;
    logic [1:0]     pos_inc;

    // Slot issued from the expander
    logic [7:0]     slot_idx;
    logic           slot_inrange;
    logic           slot_done;
    logic [3:0]     slot_shift;

    // Palette memory port
    pal_ctl_t       pal_ctl;
    logic           pal_clear;
    logic           pal_wr_en;
    logic [23:0]    pal_rd_data;
    logic           pal_rd_hit;

    // Handshake
    assign advance    = !o_valid_reg || pix_ready;
    assign issue      = (exp_cnt_reg != 4'd0) && advance;
    assign byte_ready = (exp_cnt_reg == 4'd0) || ((exp_cnt_reg == 4'd1) && advance);
    assign accept     = byte_valid && byte_ready;

    // Header field lanes
    assign off_w = hdr_idx_reg - OFF_WIDTH;
    assign off_h = hdr_idx_reg - OFF_HEIGHT;
    assign off_d = hdr_idx_reg - OFF_DEPTH;
    assign off_c = hdr_idx_reg - OFF_COLORS;

    // Header validation on the assembled fields
    always_comb
    begin
        depth_ok    = 1'b1;
        dcode_chk   = DC_8;
        pal_default = 32'd0;
        priority if (depth_reg == 16'd1)
        begin
            dcode_chk   = DC_1;
            pal_default = 32'd2;
        end
        else if (depth_reg == 16'd4)
        begin
            dcode_chk   = DC_4;
            pal_default = 32'd16;
        end
        else if (depth_reg == 16'd8)
        begin
            dcode_chk   = DC_8;
            pal_default = 32'd256;
        end
        else if (depth_reg == 16'd24)
        begin
            dcode_chk   = DC_24;
        end
        else
        begin
            depth_ok    = 1'b0;
        end

        dim_bad = (width_reg == 32'd0) || (height_reg == 32'd0)
               || (width_reg > 32'(MAX_WIDTH)) || (height_reg > 32'(MAX_HEIGHT));

        priority if (sig_reg != SIGNATURE)
        begin
            hdr_status = ST_SIGNATURE;
        end
        else if (!depth_ok)
        begin
            hdr_status = ST_DEPTH;
        end
        else if (dim_bad)
        begin
            hdr_status = ST_DIMENSION;
        end
        else
        begin
            hdr_status = ST_PIXEL;
        end
    end

    // Row length in bytes, padded to whole 32-bit words
    assign wn = width_reg[CW-1:0];

    always_comb
    begin
        unique case (dcode_chk)
            DC_1:    row_bits = BW'(wn);
            DC_4:    row_bits = BW'(wn) << 2;
            DC_8:    row_bits = BW'(wn) << 3;
            DC_24:   row_bits = (BW'(wn) << 4) + (BW'(wn) << 3);
            default: row_bits = BW'(wn);
        endcase
    end

    assign rb_round     = (BW + 1)'(row_bits) + (BW + 1)'(31);
    assign row_len_calc = RBW'({rb_round[BW:5], 2'b00});
    assign hm1          = height_reg - 32'd1;

    // Palette byte counter
    assign pal_inc     = pal_idx_reg + 34'd1;
    assign pal_end     = (pal_inc == {pcount_reg, 2'b00});
    assign pal_inrange = (pal_idx_reg[33:2] < 32'(PALETTE_DEPTH));

    // Pixels in this byte, limited by what is left of the row
    always_comb
    begin
        unique case (dcode_reg)
            DC_1:    per_byte = 4'd8;
            DC_4:    per_byte = 4'd2;
            default: per_byte = 4'd1;
        endcase
    end

    assign remaining = wn - col_reg;
    assign rem_x     = (CW + 4)'(remaining);

    always_comb
    begin
        if (col_reg >= wn)
        begin
            n_pal = 4'd0;
        end
        else if (rem_x < (CW + 4)'(per_byte))
        begin
            n_pal = rem_x[3:0];
        end
        else
        begin
            n_pal = per_byte;
        end
    end

    assign rbi_inc = rbi_reg + 1'b1;
    assign row_end = (rbi_inc == row_len_reg);
    assign pos_inc = (pos_reg == 2'd2) ? 2'd0 : pos_reg + 2'd1;

    // Parser next state
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        sig_next     = sig_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        depth_next   = depth_reg;
        pcount_next  = pcount_reg;
        pal_idx_next = pal_idx_reg;
        asm_next     = asm_reg;
        dcode_next   = dcode_reg;
        row_len_next = row_len_reg;
        rbi_next     = rbi_reg;
        pos_next     = pos_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        partial_next = partial_reg;

        pal_clear    = 1'b0;
        pal_wr_en    = 1'b0;
        load_e       = 1'b0;
        ld_cnt       = 4'd1;
        ld_byte      = data_byte;
        ld_col       = col_reg;
        ld_row       = row_reg;
        ld_direct    = 1'b0;
        ld_color     = {data_byte, partial_reg};
        ld_status    = ST_PIXEL;

        if (accept)
        begin
            if (kind)
            begin
                // Restart as after reset
                phase_next   = PH_HEADER;
                hdr_idx_next = 6'd0;
                pal_idx_next = 34'd0;
                rbi_next     = '0;
                pos_next     = 2'd0;
                col_next     = '0;
                row_next     = '0;
                partial_next = 16'd0;
                pal_clear    = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        hdr_idx_next = hdr_idx_reg + 6'd1;
                        priority if (hdr_idx_reg < OFF_SIG_END)
                        begin
                            sig_next[{hdr_idx_reg[0], 3'b000} +: 8] = data_byte;
                        end
                        else if (hdr_idx_reg >= OFF_WIDTH && hdr_idx_reg < OFF_HEIGHT)
                        begin
                            width_next[{off_w[1:0], 3'b000} +: 8] = data_byte;
                        end
                        else if (hdr_idx_reg >= OFF_HEIGHT && off_h < 6'd4)
                        begin
                            height_next[{off_h[1:0], 3'b000} +: 8] = data_byte;
                        end
                        else if (hdr_idx_reg >= OFF_DEPTH && off_d < 6'd2)
                        begin
                            depth_next[{off_d[0], 3'b000} +: 8] = data_byte;
                        end
                        else if (hdr_idx_reg >= OFF_COLORS && off_c < 6'd4)
                        begin
                            pcount_next[{off_c[1:0], 3'b000} +: 8] = data_byte;
                        end
                        else
                        begin
                        end

                        if (hdr_idx_reg == HDR_LAST)
                        begin
                            if (hdr_status != ST_PIXEL)
                            begin
                                phase_next = PH_ERROR;
                                load_e     = 1'b1;
                                ld_direct  = 1'b1;
                                ld_color   = 24'd0;
                                ld_col     = '0;
                                ld_row     = '0;
                                ld_status  = hdr_status;
                            end
                            else
                            begin
                                dcode_next   = dcode_chk;
                                row_len_next = row_len_calc;
                                pal_idx_next = 34'd0;
                                if (pcount_reg == 32'd0)
                                begin
                                    pcount_next = pal_default;
                                end
                                if (pcount_reg != 32'd0 || pal_default != 32'd0)
                                begin
                                    phase_next = PH_PALETTE;
                                end
                                else
                                begin
                                    phase_next   = PH_PIXELS;
                                    rbi_next     = '0;
                                    pos_next     = 2'd0;
                                    col_next     = '0;
                                    row_next     = hm1[RW-1:0];
                                    partial_next = 16'd0;
                                end
                            end
                        end
                    end

                    PH_PALETTE:
                    begin
                        // B, G, R collected, written whole on the third byte
                        pal_idx_next = pal_inc;
                        if (pal_inrange)
                        begin
                            unique case (pal_idx_reg[1:0])
                                2'd0:    asm_next[7:0]  = data_byte;
                                2'd1:    asm_next[15:8] = data_byte;
                                2'd2:    pal_wr_en      = 1'b1;
                                default: ;
                            endcase
                        end
                        if (pal_end)
                        begin
                            phase_next   = PH_PIXELS;
                            rbi_next     = '0;
                            pos_next     = 2'd0;
                            col_next     = '0;
                            row_next     = hm1[RW-1:0];
                            partial_next = 16'd0;
                        end
                    end

                    PH_PIXELS:
                    begin
                        rbi_next = rbi_inc;
                        pos_next = pos_inc;
                        if (dcode_reg == DC_24)
                        begin
                            if (col_reg < wn)
                            begin
                                unique case (pos_reg)
                                    2'd0: partial_next[7:0]  = data_byte;
                                    2'd1: partial_next[15:8] = data_byte;
                                    2'd2:
                                    begin
                                        load_e    = 1'b1;
                                        ld_direct = 1'b1;
                                        col_next  = col_reg + 1'b1;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        else if (n_pal != 4'd0)
                        begin
                            load_e   = 1'b1;
                            ld_cnt   = n_pal;
                            col_next = col_reg + CW'(n_pal);
                        end

                        // Padding done: next row up the image
                        if (row_end)
                        begin
                            rbi_next     = '0;
                            pos_next     = 2'd0;
                            col_next     = '0;
                            partial_next = 16'd0;
                            if (row_reg == '0)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                row_next = row_reg - 1'b1;
                            end
                        end
                    end

                    default: ;
                endcase
            end
        end
    end

    // Current slot of the expander
    always_comb
    begin
        unique case (dcode_reg)
            DC_1:
            begin
                slot_idx   = {7'd0, exp_byte_reg[7]};
                slot_shift = 4'd1;
            end
            DC_4:
            begin
                slot_idx   = {4'd0, exp_byte_reg[7:4]};
                slot_shift = 4'd4;
            end
            default:
            begin
                slot_idx   = exp_byte_reg;
                slot_shift = 4'd8;
            end
        endcase
    end

    assign slot_inrange = ({1'b0, slot_idx} < 9'(PALETTE_DEPTH));
    assign slot_done    = (exp_status_reg == ST_PIXEL) && (exp_row_reg == '0)
                       && (((CW + 1)'(exp_col_reg) + 1'b1) == (CW + 1)'(wn));

    // Expander next state
    always_comb
    begin
        exp_cnt_next    = exp_cnt_reg;
        exp_byte_next   = exp_byte_reg;
        exp_col_next    = exp_col_reg;
        exp_row_next    = exp_row_reg;
        exp_direct_next = exp_direct_reg;
        exp_color_next  = exp_color_reg;
        exp_status_next = exp_status_reg;
        if (load_e)
        begin
            exp_cnt_next    = ld_cnt;
            exp_byte_next   = ld_byte;
            exp_col_next    = ld_col;
            exp_row_next    = ld_row;
            exp_direct_next = ld_direct;
            exp_color_next  = ld_color;
            exp_status_next = ld_status;
        end
        else if (issue)
        begin
            exp_cnt_next  = exp_cnt_reg - 4'd1;
            exp_byte_next = exp_byte_reg << slot_shift;
            exp_col_next  = exp_col_reg + 1'b1;
        end
    end

    // Palette memory
    assign pal_ctl.clear      = pal_clear;
    assign pal_ctl.wr_en      = pal_wr_en;
    assign pal_ctl.rd_en      = advance;
    assign pal_ctl.rd_inrange = slot_inrange;

    bmpd_pal_ram #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (PAW)
    ) u_pal_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (pal_ctl),
        .wr_addr (pal_idx_reg[PAW+1:2]),
        .wr_data ({data_byte, asm_reg}),
        .rd_addr (slot_idx[PAW-1:0]),
        .rd_data (pal_rd_data),
        .rd_hit  (pal_rd_hit)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hdr_idx_reg <= 6'd0;
            pal_idx_reg <= 34'd0;
            rbi_reg     <= '0;
            pos_reg     <= 2'd0;
            col_reg     <= '0;
            row_reg     <= '0;
            exp_cnt_reg <= 4'd0;
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            pal_idx_reg <= pal_idx_next;
            rbi_reg     <= rbi_next;
            pos_reg     <= pos_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            exp_cnt_reg <= exp_cnt_next;
            if (advance)
            begin
                r_valid_reg <= issue;
                o_valid_reg <= r_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sig_reg        <= sig_next;
        width_reg      <= width_next;
        height_reg     <= height_next;
        depth_reg      <= depth_next;
        pcount_reg     <= pcount_next;
        asm_reg        <= asm_next;
        dcode_reg      <= dcode_next;
        row_len_reg    <= row_len_next;
        partial_reg    <= partial_next;
        exp_byte_reg   <= exp_byte_next;
        exp_col_reg    <= exp_col_next;
        exp_row_reg    <= exp_row_next;
        exp_direct_reg <= exp_direct_next;
        exp_color_reg  <= exp_color_next;
        exp_status_reg <= exp_status_next;
        if (advance)
        begin
            r_direct_reg <= exp_direct_reg;
            r_color_reg  <= exp_color_reg;
            r_status_reg <= exp_status_reg;
            r_x_reg      <= 12'(exp_col_reg);
            r_y_reg      <= 12'(exp_row_reg);
            r_last_reg   <= (exp_cnt_reg == 4'd1);
            r_done_reg   <= slot_done;

            o_x_reg      <= r_x_reg;
            o_y_reg      <= r_y_reg;
            o_status_reg <= r_status_reg;
            o_last_reg   <= r_last_reg;
            o_done_reg   <= r_done_reg;
            if (r_direct_reg)
            begin
                o_color_reg <= r_color_reg;
            end
            else if (pal_rd_hit)
            begin
                o_color_reg <= pal_rd_data;
            end
            else
            begin
                o_color_reg <= 24'd0;
            end
        end
    end

    assign pix_valid   = o_valid_reg;
    assign pixel_x     = o_x_reg;
    assign pixel_y     = o_y_reg;
    assign blue        = o_color_reg[7:0];
    assign green       = o_color_reg[15:8];
    assign red         = o_color_reg[23:16];
    assign status      = o_status_reg;
    assign last_of_run = o_last_reg;
    assign image_done  = o_done_reg;

endmodule

`default_nettype wire

/* rtl/core/bmpd_props.sv */
`timescale 1ns / 1ps
`default_nettype none

module bmpd_props (
    input logic        clk,
    input logic        rst_n,
    input logic        pix_valid,
    input logic        pix_ready,
    input logic [11:0] pixel_x,
    input logic [11:0] pixel_y,
    input logic [7:0]  blue,
    input logic [7:0]  green,
    input logic [7:0]  red,
    input logic [1:0]  status,
    input logic        last_of_run,
    input logic        image_done
);

    import bmpd_pkg::*;

    // Stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid
        && $stable({pixel_x, pixel_y, blue, green, red, status, last_of_run, image_done}))
        else $error("output word changed while stalled");

    // Error words are alone and carry no coordinates or color
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && status != ST_PIXEL |-> last_of_run && !image_done
        && pixel_x == 12'd0 && pixel_y == 12'd0
        && blue == 8'd0 && green == 8'd0 && red == 8'd0)
        else $error("malformed error word");

    // Last pixel of the image ends the run of its byte at row zero
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && image_done |-> last_of_run && status == ST_PIXEL && pixel_y == 12'd0)
        else $error("image end flagged on a word that is not the final pixel");

    // Nothing follows the last pixel until a new header has been parsed
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready && image_done |=> !pix_valid)
        else $error("word right after the end of the image");

endmodule

bind bmp_pixel_stream_decoder bmpd_props u_bmpd_props (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .status      (status),
    .last_of_run (last_of_run),
    .image_done  (image_done)
);

`default_nettype wire
